[hdl/gtlp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package gtlp_pkg;

    localparam int ANG_W  = 31;
    localparam int TRIG_W = 32;
    localparam int H_W    = 28;
    localparam int REF_W  = 34;
    localparam int OUT_W  = 35;
    localparam int N_W    = 34;

    localparam int SC_LAT = 19;
    localparam int PV_LAT = 69;
    localparam int RT_LAT = 8;

    // Squared axis ratio (b/a)^2 with 30 fraction bits.
    localparam logic [30:0] AXIS_RATIO_SQ_Q30 = 31'd1066553789;

    typedef enum logic [1:0] {
        REG_REF_X = 2'd0,
        REG_REF_Y = 2'd1,
        REG_REF_Z = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0] sla;
        logic signed [TRIG_W-1:0] cla;
        logic signed [TRIG_W-1:0] slo;
        logic signed [TRIG_W-1:0] clo;
    } trig_t;

    typedef struct packed {
        trig_t                 trig;
        logic signed [H_W-1:0] h;
    } side_t;

endpackage

`default_nettype wire

[hdl/gtlp_sincos.sv]
`timescale 1ns / 1ps
`default_nettype none

module gtlp_sincos (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [gtlp_pkg::ANG_W-1:0]    ang,
    output logic signed [gtlp_pkg::TRIG_W-1:0]   sin_q30,
    output logic signed [gtlp_pkg::TRIG_W-1:0]   cos_q30
);
    import gtlp_pkg::*;

    localparam logic [31:0] DEG_Q45  = 32'd188743680;
    localparam logic [31:0] DEG_Q90  = 32'd377487360;
    localparam logic [31:0] DEG_Q180 = 32'd754974720;
    localparam logic [31:0] DEG_Q270 = 32'd1132462080;
    localparam logic [31:0] DEG_Q360 = 32'd1509949440;
    localparam logic [30:0] ONE      = 31'h40000000;
    localparam logic [36:0] RAD_PER_DEG_Q42 = 37'd76760392275;
    localparam logic [18:0] RAD_HI = RAD_PER_DEG_Q42[36:18];
    localparam logic [17:0] RAD_LO = RAD_PER_DEG_Q42[17:0];

    localparam logic [63:0] SIN_M [5] = '{
        ((64'd1 << 38) + 64'd109) / 64'd110,
        ((64'd1 << 38) + 64'd71) / 64'd72,
        ((64'd1 << 37) + 64'd41) / 64'd42,
        ((64'd1 << 36) + 64'd19) / 64'd20,
        ((64'd1 << 34) + 64'd5) / 64'd6
    };
    localparam int SIN_SH [5] = '{38, 38, 37, 36, 34};
    localparam logic [63:0] COS_M [6] = '{
        ((64'd1 << 39) + 64'd131) / 64'd132,
        ((64'd1 << 38) + 64'd89) / 64'd90,
        ((64'd1 << 37) + 64'd55) / 64'd56,
        ((64'd1 << 36) + 64'd29) / 64'd30,
        ((64'd1 << 35) + 64'd11) / 64'd12,
        ((64'd1 << 32) + 64'd1) / 64'd2
    };
    localparam int COS_SH [6] = '{39, 38, 37, 36, 35, 32};

    function automatic logic [30:0] mul_round(input logic [30:0] a, input logic [30:0] b);
        logic [61:0] p;
        p = 62'(a) * 62'(b) + 62'h20000000;
        return p[60:30];
    endfunction

    function automatic logic [30:0] div_const(input logic [30:0] v, input logic [31:0] m,
                                              input int sh);
        logic [62:0] p;
        p = 63'(v) * 63'(m);
        return 31'(p >> sh);
    endfunction

    logic [31:0] ang_ext;
    logic [31:0] t_reg;
    logic [1:0]  k2_reg, k2_next;
    logic [28:0] r2_reg, r2_next;
    logic [31:0] off;
    logic [1:0]  k3_reg, k4_reg, k5_reg;
    logic        sw3_reg, sw4_reg, sw5_reg;
    logic [27:0] rp3_reg;
    logic [46:0] phi4_reg;
    logic [45:0] plo4_reg;
    logic [64:0] xsum;
    logic [29:0] x5_reg;

    logic [29:0] hx_reg  [0:10];
    logic [29:0] hx2_reg [0:10];
    logic [1:0]  hk_reg  [0:12];
    logic        hsw_reg [0:12];
    logic [30:0] hs_reg  [0:12];
    logic [30:0] hc_reg  [0:12];

    logic [30:0] s_sw, c_sw;
    logic signed [31:0] sx, cx;
    logic signed [TRIG_W-1:0] sin_reg, cos_reg, sin_next, cos_next;

    assign ang_ext = {ang[ANG_W-1], ang};

    always_comb begin
        if (t_reg >= DEG_Q270) begin
            k2_next = 2'd3;
            off     = DEG_Q270;
        end else if (t_reg >= DEG_Q180) begin
            k2_next = 2'd2;
            off     = DEG_Q180;
        end else if (t_reg >= DEG_Q90) begin
            k2_next = 2'd1;
            off     = DEG_Q90;
        end else begin
            k2_next = 2'd0;
            off     = 32'd0;
        end
        r2_next = 29'(t_reg - off);
    end

    assign xsum = (65'(phi4_reg) << 18) + 65'(plo4_reg) + (65'd1 << 33);

    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg    <= ang_ext + (ang[ANG_W-1] ? DEG_Q360 : 32'd0);
            k2_reg   <= k2_next;
            r2_reg   <= r2_next;
            k3_reg   <= k2_reg;
            sw3_reg  <= 32'(r2_reg) > DEG_Q45;
            rp3_reg  <= (32'(r2_reg) > DEG_Q45) ? 28'(DEG_Q90 - 32'(r2_reg)) : 28'(r2_reg);
            k4_reg   <= k3_reg;
            sw4_reg  <= sw3_reg;
            phi4_reg <= 47'(rp3_reg) * 47'(RAD_HI);
            plo4_reg <= 46'(rp3_reg) * 46'(RAD_LO);
            k5_reg   <= k4_reg;
            sw5_reg  <= sw4_reg;
            x5_reg   <= xsum[63:34];
            hx_reg[0]  <= x5_reg;
            hx2_reg[0] <= 30'(mul_round(31'(x5_reg), 31'(x5_reg)));
            hk_reg[0]  <= k5_reg;
            hsw_reg[0] <= sw5_reg;
            hs_reg[0]  <= ONE;
            hc_reg[0]  <= ONE;
        end
    end

    for (genvar j = 0; j < 6; j++) begin : g_slot
        always_ff @(posedge aclk) begin
            if (en) begin
                hc_reg[2*j+1]  <= mul_round(31'(hx2_reg[2*j]), hc_reg[2*j]);
                hc_reg[2*j+2]  <= ONE - div_const(hc_reg[2*j+1], COS_M[j][31:0], COS_SH[j]);
                hk_reg[2*j+1]  <= hk_reg[2*j];
                hk_reg[2*j+2]  <= hk_reg[2*j+1];
                hsw_reg[2*j+1] <= hsw_reg[2*j];
                hsw_reg[2*j+2] <= hsw_reg[2*j+1];
            end
        end
        if (j < 5) begin : g_sin
            always_ff @(posedge aclk) begin
                if (en) begin
                    hs_reg[2*j+1]  <= mul_round(31'(hx2_reg[2*j]), hs_reg[2*j]);
                    hs_reg[2*j+2]  <= ONE - div_const(hs_reg[2*j+1], SIN_M[j][31:0],
                                                      SIN_SH[j]);
                    hx_reg[2*j+1]  <= hx_reg[2*j];
                    hx_reg[2*j+2]  <= hx_reg[2*j+1];
                    hx2_reg[2*j+1] <= hx2_reg[2*j];
                    hx2_reg[2*j+2] <= hx2_reg[2*j+1];
                end
            end
        end else begin : g_sin_final
            always_ff @(posedge aclk) begin
                if (en) begin
                    hs_reg[2*j+1] <= mul_round(31'(hx_reg[2*j]), hs_reg[2*j]);
                    hs_reg[2*j+2] <= hs_reg[2*j+1];
                end
            end
        end
    end

    always_comb begin
        s_sw = hsw_reg[12] ? hc_reg[12] : hs_reg[12];
        c_sw = hsw_reg[12] ? hs_reg[12] : hc_reg[12];
        sx   = $signed({1'b0, s_sw});
        cx   = $signed({1'b0, c_sw});
        case (hk_reg[12])
            2'd0: begin
                sin_next = sx;
                cos_next = cx;
            end
            2'd1: begin
                sin_next = cx;
                cos_next = -sx;
            end
            2'd2: begin
                sin_next = -sx;
                cos_next = -cx;
            end
            default: begin
                sin_next = -cx;
                cos_next = sx;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule

`default_nettype wire

[hdl/gtlp_prime_vertical.sv]
`timescale 1ns / 1ps
`default_nettype none

module gtlp_prime_vertical (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [gtlp_pkg::TRIG_W-1:0] sin_q30,
    input  logic signed [gtlp_pkg::TRIG_W-1:0] cos_q30,
    output logic [gtlp_pkg::N_W-1:0]           radius_mm
);
    import gtlp_pkg::*;

    localparam logic [63:0] SEMI_MAJOR_SHIFTED = 64'd6378137000 << 31;
    localparam logic [31:0] SQ_FLOOR = 32'h40000000;

    logic [30:0] us, uc;
    logic [60:0] uc2_reg;
    logic [61:0] us2_full;
    logic [30:0] us2r_reg;
    logic [61:0] d_sum;

    logic [63:0] sv_reg [0:31];
    logic [63:0] sr_reg [0:32];

    logic [31:0] sq_clamped;
    logic [63:0] drem_reg [0:33];
    logic [31:0] dsq_reg  [0:33];
    logic [N_W-1:0] dq_reg [0:34];

    assign us       = 31'(sin_q30[TRIG_W-1] ? -sin_q30 : sin_q30);
    assign uc       = 31'(cos_q30[TRIG_W-1] ? -cos_q30 : cos_q30);
    assign us2_full = 62'(us) * 62'(us) + 62'h20000000;
    assign d_sum    = 62'(uc2_reg) + 62'(us2r_reg) * 62'(AXIS_RATIO_SQ_Q30);

    always_ff @(posedge aclk) begin
        if (en) begin
            uc2_reg   <= 61'(62'(uc) * 62'(uc));
            us2r_reg  <= us2_full[60:30];
            sv_reg[0] <= {d_sum, 2'b00};
            sr_reg[0] <= 64'd0;
        end
    end

    for (genvar i = 0; i < 32; i++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
        logic [63:0] trial;
        logic        take;
        assign trial = sr_reg[i] + BIT;
        assign take  = sv_reg[i] >= trial;
        always_ff @(posedge aclk) begin
            if (en) begin
                sr_reg[i+1] <= take ? (sr_reg[i] >> 1) + BIT : sr_reg[i] >> 1;
            end
        end
        if (i < 31) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    sv_reg[i+1] <= take ? sv_reg[i] - trial : sv_reg[i];
                end
            end
        end
    end

    assign sq_clamped = (sr_reg[32] < 64'(SQ_FLOOR)) ? SQ_FLOOR : sr_reg[32][31:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            dsq_reg[0]  <= sq_clamped;
            drem_reg[0] <= SEMI_MAJOR_SHIFTED + 64'(sq_clamped >> 1);
            dq_reg[0]   <= '0;
        end
    end

    for (genvar i = 0; i < 34; i++) begin : g_div
        localparam int B = 33 - i;
        logic [66:0] cmp;
        logic        take;
        assign cmp  = 67'(dsq_reg[i]) << B;
        assign take = 67'(drem_reg[i]) >= cmp;
        always_ff @(posedge aclk) begin
            if (en) begin
                dq_reg[i+1] <= take ? (dq_reg[i] | (N_W'(1) << B)) : dq_reg[i];
            end
        end
        if (i < 33) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en) begin
                    drem_reg[i+1] <= take ? 64'(67'(drem_reg[i]) - cmp) : drem_reg[i];
                    dsq_reg[i+1]  <= dsq_reg[i];
                end
            end
        end
    end

    assign radius_mm = dq_reg[34];

endmodule

`default_nettype wire

[hdl/gtlp_rotate.sv]
`timescale 1ns / 1ps
`default_nettype none

module gtlp_rotate (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [gtlp_pkg::N_W-1:0]          radius_mm,
    input  gtlp_pkg::side_t                   side,
    input  logic signed [gtlp_pkg::REF_W-1:0] ref_x,
    input  logic signed [gtlp_pkg::REF_W-1:0] ref_y,
    input  logic signed [gtlp_pkg::REF_W-1:0] ref_z,
    output logic signed [gtlp_pkg::OUT_W-1:0] local_x_mm,
    output logic signed [gtlp_pkg::OUT_W-1:0] local_y_mm,
    output logic signed [gtlp_pkg::OUT_W-1:0] local_z_mm
);
    import gtlp_pkg::*;

    localparam logic signed [38:0] OUT_LIMIT = 39'sd13000000000;

    function automatic logic signed [39:0] mulq(input logic signed [39:0] p,
                                               input logic signed [31:0] q);
        logic [39:0] up;
        logic [31:0] uq;
        logic [71:0] prod;
        logic [39:0] r;
        up   = p[39] ? 40'(-p) : 40'(p);
        uq   = q[31] ? 32'(-q) : 32'(q);
        prod = 72'(up) * 72'(uq) + 72'h20000000;
        r    = prod[69:30];
        return (p[39] ^ q[31]) ? -r : r;
    endfunction

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [38:0] v);
        if (v > OUT_LIMIT) begin
            return OUT_W'(OUT_LIMIT);
        end else if (v < -OUT_LIMIT) begin
            return OUT_W'(-OUT_LIMIT);
        end
        return OUT_W'(v);
    endfunction

    logic signed [31:0] k_signed;
    logic signed [39:0] n_signed;

    side_t              side1_reg;
    trig_t              tr_reg [2:6];
    logic signed [35:0] nh1_reg, rc2_reg, ezs2_reg, ex3_reg, ey3_reg, ez3_reg;
    logic signed [34:0] nk1_reg;
    logic signed [36:0] dx4_reg, dy4_reg, dz4_reg;
    logic signed [36:0] pa5_reg, pb5_reg, pc5_reg, pd5_reg, dy5_reg;
    logic signed [37:0] ux6_reg, uz6_reg;
    logic signed [36:0] uy6_reg;
    logic signed [37:0] qa7_reg, qb7_reg, qc7_reg, qd7_reg, ux7_reg;
    logic signed [38:0] wy_next, wz_next;
    logic signed [OUT_W-1:0] x_reg, y_reg, z_reg;

    assign k_signed = $signed({1'b0, AXIS_RATIO_SQ_Q30});
    assign n_signed = $signed({6'b0, radius_mm});
    assign wy_next  = 39'(qa7_reg) + 39'(qb7_reg);
    assign wz_next  = 39'(qc7_reg) - 39'(qd7_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg <= side;
            nh1_reg   <= 36'(n_signed) + 36'(side.h);
            nk1_reg   <= 35'(mulq(n_signed, k_signed));

            tr_reg[2] <= side1_reg.trig;
            rc2_reg   <= 36'(mulq(40'(nh1_reg), side1_reg.trig.cla));
            ezs2_reg  <= 36'(nk1_reg) + 36'(side1_reg.h);

            tr_reg[3] <= tr_reg[2];
            ex3_reg   <= 36'(mulq(40'(rc2_reg), tr_reg[2].clo));
            ey3_reg   <= 36'(mulq(40'(rc2_reg), tr_reg[2].slo));
            ez3_reg   <= 36'(mulq(40'(ezs2_reg), tr_reg[2].sla));

            tr_reg[4] <= tr_reg[3];
            dx4_reg   <= 37'(ex3_reg) - 37'(ref_x);
            dy4_reg   <= 37'(ey3_reg) - 37'(ref_y);
            dz4_reg   <= 37'(ez3_reg) - 37'(ref_z);

            tr_reg[5] <= tr_reg[4];
            pa5_reg   <= 37'(mulq(40'(dx4_reg), tr_reg[4].sla));
            pb5_reg   <= 37'(mulq(40'(dz4_reg), tr_reg[4].cla));
            pc5_reg   <= 37'(mulq(40'(dx4_reg), tr_reg[4].cla));
            pd5_reg   <= 37'(mulq(40'(dz4_reg), tr_reg[4].sla));
            dy5_reg   <= dy4_reg;

            tr_reg[6] <= tr_reg[5];
            ux6_reg   <= 38'(pa5_reg) - 38'(pb5_reg);
            uz6_reg   <= 38'(pc5_reg) + 38'(pd5_reg);
            uy6_reg   <= dy5_reg;

            qa7_reg   <= 38'(mulq(40'(uy6_reg), tr_reg[6].clo));
            qb7_reg   <= 38'(mulq(40'(uz6_reg), tr_reg[6].slo));
            qc7_reg   <= 38'(mulq(40'(uz6_reg), tr_reg[6].clo));
            qd7_reg   <= 38'(mulq(40'(uy6_reg), tr_reg[6].slo));
            ux7_reg   <= ux6_reg;

            x_reg     <= sat_out(wy_next);
            y_reg     <= sat_out(wz_next);
            z_reg     <= sat_out(39'(ux7_reg));
        end
    end

    assign local_x_mm = x_reg;
    assign local_y_mm = y_reg;
    assign local_z_mm = z_reg;

endmodule

`default_nettype wire

[hdl/geodetic_to_local_position_top.sv]
// Throughput: one word per cycle while the skid register is empty, set by the fully
// pipelined square root (one root bit per stage) and the restoring divider (one
// quotient bit per stage). Reset clears all valid bits, including the output and skid
// valid flags, and sets the reference registers to zero; data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module geodetic_to_local_position_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [29:0]                  s_lat_deg_q22,
    input  logic signed [30:0]                  s_lon_deg_q22,
    input  logic signed [gtlp_pkg::H_W-1:0]     s_alt_mm,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [gtlp_pkg::OUT_W-1:0]   m_local_x_mm,
    output logic signed [gtlp_pkg::OUT_W-1:0]   m_local_y_mm,
    output logic signed [gtlp_pkg::OUT_W-1:0]   m_local_z_mm,
    input  logic                                cfg_wr_en,
    input  logic [1:0]                          cfg_index,
    input  logic [gtlp_pkg::REF_W-1:0]          cfg_data
);
    import gtlp_pkg::*;

    localparam int PIPE_LAT = SC_LAT + PV_LAT + RT_LAT;

    logic en;
    logic [PIPE_LAT-1:0] vld_reg;

    logic signed [REF_W-1:0] ref_x_reg, ref_y_reg, ref_z_reg;

    logic signed [TRIG_W-1:0] sla, cla, slo, clo;
    logic [N_W-1:0]           radius_mm;
    logic signed [H_W-1:0]    h_dly_reg [SC_LAT];
    side_t                    side_dly_reg [PV_LAT];
    side_t                    side_in;

    logic signed [OUT_W-1:0] rot_x, rot_y, rot_z;
    logic signed [OUT_W-1:0] out_x_reg, out_y_reg, out_z_reg;
    logic signed [OUT_W-1:0] skid_x_reg, skid_y_reg, skid_z_reg;
    logic                    out_vld_reg, skid_vld_reg;

    assign en      = !skid_vld_reg;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ref_x_reg <= '0;
            ref_y_reg <= '0;
            ref_z_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_REF_X: ref_x_reg <= $signed(cfg_data);
                REG_REF_Y: ref_y_reg <= $signed(cfg_data);
                REG_REF_Z: ref_z_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_valid};
        end
    end

    gtlp_sincos u_sincos_lat (
        .aclk    (aclk),
        .en      (en),
        .ang     (ANG_W'(s_lat_deg_q22)),
        .sin_q30 (sla),
        .cos_q30 (cla)
    );

    gtlp_sincos u_sincos_lon (
        .aclk    (aclk),
        .en      (en),
        .ang     (s_lon_deg_q22),
        .sin_q30 (slo),
        .cos_q30 (clo)
    );

    gtlp_prime_vertical u_prime_vertical (
        .aclk      (aclk),
        .en        (en),
        .sin_q30   (sla),
        .cos_q30   (cla),
        .radius_mm (radius_mm)
    );

    always_comb begin
        side_in.trig.sla = sla;
        side_in.trig.cla = cla;
        side_in.trig.slo = slo;
        side_in.trig.clo = clo;
        side_in.h        = h_dly_reg[SC_LAT-1];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_dly_reg[0] <= s_alt_mm;
            for (int i = 1; i < SC_LAT; i++) begin
                h_dly_reg[i] <= h_dly_reg[i-1];
            end
            side_dly_reg[0] <= side_in;
            for (int i = 1; i < PV_LAT; i++) begin
                side_dly_reg[i] <= side_dly_reg[i-1];
            end
        end
    end

    gtlp_rotate u_rotate (
        .aclk       (aclk),
        .en         (en),
        .radius_mm  (radius_mm),
        .side       (side_dly_reg[PV_LAT-1]),
        .ref_x      (ref_x_reg),
        .ref_y      (ref_y_reg),
        .ref_z      (ref_z_reg),
        .local_x_mm (rot_x),
        .local_y_mm (rot_y),
        .local_z_mm (rot_z)
    );

    // The skid register catches the word leaving the pipeline while the output waits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (out_vld_reg && !m_ready) begin
            if (en && vld_reg[PIPE_LAT-1]) begin
                skid_vld_reg <= 1'b1;
            end
        end else if (skid_vld_reg) begin
            out_vld_reg  <= 1'b1;
            skid_vld_reg <= 1'b0;
        end else begin
            out_vld_reg <= vld_reg[PIPE_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_vld_reg && !m_ready) begin
            if (en && vld_reg[PIPE_LAT-1]) begin
                skid_x_reg <= rot_x;
                skid_y_reg <= rot_y;
                skid_z_reg <= rot_z;
            end
        end else if (skid_vld_reg) begin
            out_x_reg <= skid_x_reg;
            out_y_reg <= skid_y_reg;
            out_z_reg <= skid_z_reg;
        end else begin
            out_x_reg <= rot_x;
            out_y_reg <= rot_y;
            out_z_reg <= rot_z;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_local_x_mm = out_x_reg;
    assign m_local_y_mm = out_y_reg;
    assign m_local_z_mm = out_z_reg;

endmodule

`default_nettype wire

[tb/geodetic_to_local_position_top_test.sv]
`timescale 1ns / 1ps

module geodetic_to_local_position_top_test;
    import gtlp_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam longint DEG_Q45 = 64'sd188743680;
    localparam longint DEG_Q90 = 64'sd377487360;
    localparam longint DEG_Q360 = 64'sd1509949440;
    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint AXIS_K = 64'sd1066553789;
    localparam longint OUT_LIMIT = 64'sd13000000000;
    localparam longint REF_SPAN = 64'sd6500000000;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD = 400;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
    } local_pos_t;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic signed [29:0] s_lat_deg_q22;
    logic signed [30:0] s_lon_deg_q22;
    logic signed [H_W-1:0] s_alt_mm;
    logic m_valid;
    logic m_ready;
    logic signed [OUT_W-1:0] m_local_x_mm;
    logic signed [OUT_W-1:0] m_local_y_mm;
    logic signed [OUT_W-1:0] m_local_z_mm;
    logic cfg_wr_en;
    logic [1:0] cfg_index;
    logic [REF_W-1:0] cfg_data;

    longint origin_x_mm;
    longint origin_y_mm;
    longint origin_z_mm;
    local_pos_t pending_positions[$];
    int error_count;
    int quiet_cycles;
    bit no_idle;
    bit long_hold_req;

    geodetic_to_local_position_top dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_lat_deg_q22(s_lat_deg_q22),
        .s_lon_deg_q22(s_lon_deg_q22),
        .s_alt_mm(s_alt_mm),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_local_x_mm(m_local_x_mm),
        .m_local_y_mm(m_local_y_mm),
        .m_local_z_mm(m_local_z_mm),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint mul_q30(longint p, longint q);
        logic [127:0] prod;
        longint unsigned up;
        longint unsigned uq;
        longint mag;
        bit neg;
        neg = (p < 0) != (q < 0);
        up = (p < 0) ? -p : p;
        uq = (q < 0) ? -q : q;
        prod = up * uq;
        prod = prod + (128'd1 << 29);
        mag = longint'(prod >> 30);
        return neg ? -mag : mag;
    endfunction

    function automatic void trig_of_angle(longint ang, output longint s_out,
                                          output longint c_out);
        longint t;
        longint r;
        longint x;
        longint x2;
        longint ts;
        longint tc;
        longint s;
        longint c;
        longint tmp;
        longint unsigned rad;
        longint sdiv[5];
        longint cdiv[6];
        int k;
        bit swap;
        sdiv = '{110, 72, 42, 20, 6};
        cdiv = '{132, 90, 56, 30, 12, 2};
        t = ang % DEG_Q360;
        if (t < 0) t += DEG_Q360;
        k = int'(t / DEG_Q90);
        r = t - longint'(k) * DEG_Q90;
        swap = r > DEG_Q45;
        if (swap) r = DEG_Q90 - r;
        rad = longint'(r) * 64'd76760392275 + (64'd1 << 33);
        x = longint'(rad >> 34);
        x2 = mul_q30(x, x);
        ts = Q30_ONE;
        for (int i = 0; i < 5; i++) ts = Q30_ONE - mul_q30(x2, ts) / sdiv[i];
        tc = Q30_ONE;
        for (int i = 0; i < 6; i++) tc = Q30_ONE - mul_q30(x2, tc) / cdiv[i];
        s = mul_q30(x, ts);
        c = tc;
        if (swap) begin
            tmp = s;
            s = c;
            c = tmp;
        end
        case (k & 3)
            0: begin s_out = s; c_out = c; end
            1: begin s_out = c; c_out = -s; end
            2: begin s_out = -s; c_out = -c; end
            default: begin s_out = -c; c_out = s; end
        endcase
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint vertical_radius(longint s, longint c);
        longint unsigned us;
        longint unsigned uc;
        longint unsigned d;
        longint unsigned sq;
        us = (s < 0) ? -s : s;
        uc = (c < 0) ? -c : c;
        d = uc * uc + ((us * us + (64'd1 << 29)) >> 30) * 64'd1066553789;
        sq = root_floor(d << 2);
        if (sq < (64'd1 << 30)) sq = 64'd1 << 30;
        return longint'(((64'd6378137000 << 31) + sq / 2) / sq);
    endfunction

    function automatic logic signed [OUT_W-1:0] clip_mm(longint v);
        if (v > OUT_LIMIT) v = OUT_LIMIT;
        if (v < -OUT_LIMIT) v = -OUT_LIMIT;
        return v[OUT_W-1:0];
    endfunction

    function automatic local_pos_t predict_local(logic signed [29:0] lat,
                                                 logic signed [30:0] lon,
                                                 logic signed [H_W-1:0] alt);
        longint sla, cla, slo, clo, n, h, rc, dx, dy, dz, ux, uz;
        local_pos_t p;
        h = alt;
        trig_of_angle(lat, sla, cla);
        trig_of_angle(lon, slo, clo);
        n = vertical_radius(sla, cla);
        rc = mul_q30(n + h, cla);
        dx = mul_q30(rc, clo) - origin_x_mm;
        dy = mul_q30(rc, slo) - origin_y_mm;
        dz = mul_q30(mul_q30(n, AXIS_K) + h, sla) - origin_z_mm;
        ux = mul_q30(dx, sla) - mul_q30(dz, cla);
        uz = mul_q30(dx, cla) + mul_q30(dz, sla);
        p.x = clip_mm(mul_q30(dy, clo) + mul_q30(uz, slo));
        p.y = clip_mm(mul_q30(uz, clo) - mul_q30(dy, slo));
        p.z = clip_mm(ux);
        return p;
    endfunction

    task automatic report_mismatch(string field, longint exp_v, longint got_v);
        $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, field,
                 exp_v, got_v);
        error_count++;
    endtask

    always @(posedge aclk) begin
        local_pos_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_positions.size() == 0) begin
                $display("%0t: result word with no point outstanding", $realtime);
                error_count++;
            end else begin
                e = pending_positions.pop_front();
                if (m_local_x_mm !== e.x) report_mismatch("local_x_mm", e.x, m_local_x_mm);
                if (m_local_y_mm !== e.y) report_mismatch("local_y_mm", e.y, m_local_y_mm);
                if (m_local_z_mm !== e.z) report_mismatch("local_z_mm", e.z, m_local_z_mm);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int n;
        m_ready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_hold_req) begin
                n = LONG_HOLD;
                long_hold_req = 1'b0;
            end else begin
                n = no_idle ? 0 : $urandom_range(0, 10);
            end
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    task automatic send_point(logic signed [29:0] lat, logic signed [30:0] lon,
                              logic signed [H_W-1:0] alt);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_lat_deg_q22 <= lat;
        s_lon_deg_q22 <= lon;
        s_alt_mm <= alt;
        do @(posedge aclk); while (!s_ready);
        pending_positions.push_back(predict_local(lat, lon, alt));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_positions.size() != 0) @(posedge aclk);
        repeat (RT_LAT + PV_LAT + SC_LAT + 10) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, longint value);
        logic [REF_W-1:0] bits;
        bits = value[REF_W-1:0];
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= bits;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_REF_X: origin_x_mm = $signed(bits);
            REG_REF_Y: origin_y_mm = $signed(bits);
            REG_REF_Z: origin_z_mm = $signed(bits);
            default: ;
        endcase
    endtask

    function automatic logic signed [29:0] rand_lat();
        if ($urandom_range(0, 3) == 0) return 30'($urandom);
        return 30'(longint'($urandom_range(0, 2 * 377487360)) - 64'sd377487360);
    endfunction

    function automatic logic signed [30:0] rand_lon();
        if ($urandom_range(0, 3) == 0) return 31'($urandom);
        return 31'(longint'($urandom_range(0, 2 * 754974720)) - 64'sd754974720);
    endfunction

    function automatic logic signed [H_W-1:0] rand_alt();
        if ($urandom_range(0, 3) == 0) return H_W'($urandom);
        return H_W'(longint'($urandom_range(0, 101000000)) - 64'sd1000000);
    endfunction

    function automatic longint rand_ref();
        longint v;
        if ($urandom_range(0, 3) == 0) begin
            v = {$urandom, $urandom};
            return v;
        end
        return longint'({$urandom, $urandom} % 64'd13000000001) - REF_SPAN;
    endfunction

    task automatic test_field_extremes();
        send_point(0, 0, 0);
        send_point(30'sd377487360, 0, 0);
        send_point(-30'sd377487360, 0, 0);
        send_point(30'sd188743680, 31'sd188743680, 1000);
        send_point(30'sd188743681, -31'sd188743681, -1000);
        send_point(0, 31'sd377487360, 0);
        send_point(0, -31'sd377487360, 0);
        send_point(0, 31'sd754974720, 28'sd100000000);
        send_point(0, -31'sd754974720, -28'sd1000000);
        send_point(30'sh1FFFFFFF, 31'sh3FFFFFFF, 28'sh7FFFFFF);
        send_point(30'sh20000000, 31'sh40000000, 28'sh8000000);
        send_point(30'sh3FFFFFFF, 31'sh7FFFFFFF, -28'sd1);
        send_point(30'sd377487361, 31'sd754974721, 28'sd12345);
        send_point(-30'sd41943040, 31'sd1000000000, 28'sd5000000);
        send_point(30'sd200000000, 31'sd600000000, 28'sd77);
        wait_drained();
    endtask

    task automatic test_reference_registers();
        longint vals[6];
        vals = '{REF_SPAN, -REF_SPAN, 64'sd8589934591, -64'sd8589934592, 64'sd0,
                 64'sd4000000000};
        foreach (vals[i]) begin
            write_reg(REG_REF_X, vals[i]);
            write_reg(REG_REF_Y, vals[(i + 2) % 6]);
            write_reg(REG_REF_Z, vals[(i + 4) % 6]);
            write_reg(REG_UNUSED, -64'sd1);
            send_point(0, 0, 0);
            send_point(-30'sd377487360, 31'sd754974720, 28'sd100000000);
            send_point(30'sd377487360, 31'sd377487360, -28'sd1000000);
            send_point(rand_lat(), rand_lon(), rand_alt());
            wait_drained();
        end
    endtask

    task automatic test_random_points();
        for (int blk = 0; blk < 14; blk++) begin
            write_reg(REG_REF_X, rand_ref());
            write_reg(REG_REF_Y, rand_ref());
            write_reg(REG_REF_Z, rand_ref());
            if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, rand_ref());
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (50) send_point(rand_lat(), rand_lon(), rand_alt());
            no_idle = 1'b0;
            wait_drained();
        end
    endtask

    task automatic test_output_backpressure();
        no_idle = 1'b1;
        long_hold_req = 1'b1;
        repeat (150) send_point(rand_lat(), rand_lon(), rand_alt());
        no_idle = 1'b0;
        wait_drained();
    endtask

    task automatic test_sender_pause();
        repeat (40) send_point(rand_lat(), rand_lon(), rand_alt());
        s_valid <= 1'b0;
        while (pending_positions.size() != 0) @(posedge aclk);
        repeat (40) send_point(rand_lat(), rand_lon(), rand_alt());
        wait_drained();
    endtask

    initial begin
        error_count = 0;
        no_idle = 1'b0;
        long_hold_req = 1'b0;
        origin_x_mm = 0;
        origin_y_mm = 0;
        origin_z_mm = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_lat_deg_q22 <= '0;
        s_lon_deg_q22 <= '0;
        s_alt_mm <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_REF_X;
        cfg_data <= '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_field_extremes();
        test_reference_registers();
        test_random_points();
        test_output_backpressure();
        test_sender_pause();
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
